FILE: hw/rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: item structs,
// command and status codes, and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Default ring depth
    localparam int DEPTH_DEF = 16;

    // Width of the reported item count (count is reported modulo 32)
    localparam int COUNT_W = 5;

    // Command codes; unused codes behave as a query
    typedef enum logic [2:0] {
        CMD_PUSH_HEAD = 3'd0,
        CMD_PUSH_TAIL = 3'd1,
        CMD_POP_HEAD  = 3'd2,
        CMD_POP_TAIL  = 3'd3,
        CMD_QUERY     = 3'd4
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // One input item
    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] item_value;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] popped_value;
        logic [COUNT_W-1:0] item_count;
        logic               is_empty;
    } t_out_item;

    // Controller commands to the datapath
    typedef struct packed {
        logic accept;   // latch the item and read the ring
        logic commit;   // update the ring and load the result
    } t_dp_cmd;

endpackage

FILE: hw/rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values held in a ring of
// DEPTH entries: push or pop at either end, or query, one result per item.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------
//   in      | to block  | i_in_valid / o_in_stall  | i_in_item  (t_in_item)
//   out     | from block| o_out_valid / i_out_stall| o_out_item (t_out_item)
//
// Each item is accepted with a registered ring memory read, then
// committed: the ring is updated and the result register loaded.
// Items are taken one at a time, so a new item is accepted only once
// the last one has committed. A result waiting under stall holds and lets
// one more item be accepted; that item commits once the result is taken.
// Reset (synchronous, active low) empties the queue; ring contents are not
// cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  deq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output deq_pkg::t_out_item o_out_item
);

    deq_pkg::t_dp_cmd dp_cmd;

    // Sequence items
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dp_cmd    (dp_cmd)
    );

    // Hold the ring and compute results
    deq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dp_cmd   (dp_cmd),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule

FILE: hw/rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller for the double-ended queue: takes one item at a time, waits
// for the ring read, then commits once the result register is free.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output deq_pkg::t_dp_cmd o_dp_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   commit;

    // Take an item only when no item is in work
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = (r_state == S_IDLE) && i_in_valid;
    // Commit when the result register is empty or being drained
    assign commit      = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;

    assign o_dp_cmd.accept = accept;
    assign o_dp_cmd.commit = commit;

    // Next state and result valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hw/rtl/deq_dpath.sv
// ----------------------------------------------------------------------------
// deq_dpath
// Datapath for the double-ended queue: ring memory, front index, item
// count, registered ring read and the result register.
// ----------------------------------------------------------------------------
module deq_dpath #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  deq_pkg::t_dp_cmd   i_dp_cmd,
    input  deq_pkg::t_in_item  i_in_item,
    output deq_pkg::t_out_item o_out_item
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 2;

    logic [31:0]        mem [DEPTH];

    logic [2:0]         r_cmd;
    logic [31:0]        r_value;
    logic [31:0]        r_rd_data;
    logic [IDX_W-1:0]   r_front;
    logic [CNT_W-1:0]   r_count;
    deq_pkg::t_out_item r_out;

    logic [IDX_W-1:0]   n_front;
    logic [CNT_W-1:0]   n_count;
    deq_pkg::t_out_item n_out;

    logic [IDX_W-1:0]   front_inc;
    logic [IDX_W-1:0]   front_dec;
    logic [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:0]   sum_last;
    logic [IDX_W-1:0]   tail_next;
    logic [IDX_W-1:0]   tail_last;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               wr_en;
    logic               is_full;
    logic               is_empty;
    logic [31:0]        count_ext;

    // Ring neighbors of the front index
    assign front_inc = (r_front == IDX_W'(DEPTH - 1)) ? '0 : r_front + 1'b1;
    assign front_dec = (r_front == '0) ? IDX_W'(DEPTH - 1) : r_front - 1'b1;

    // Slot after the tail and the tail slot, wrapped by one compare
    assign sum_next  = SUM_W'(r_front) + SUM_W'(r_count);
    assign sum_last  = sum_next - 1'b1;
    assign tail_next = (sum_next >= SUM_W'(DEPTH)) ? IDX_W'(sum_next - SUM_W'(DEPTH))
                                                   : IDX_W'(sum_next);
    assign tail_last = (r_count == '0) ? r_front
                     : (sum_last >= SUM_W'(DEPTH)) ? IDX_W'(sum_last - SUM_W'(DEPTH))
                                                   : IDX_W'(sum_last);

    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);

    // Pop at the head reads the front slot, anything else the tail slot
    assign rd_addr = (i_in_item.command == deq_pkg::CMD_POP_HEAD) ? r_front : tail_last;

    // Latch the item and read the ring on accept
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.accept) begin
            r_cmd     <= i_in_item.command;
            r_value   <= i_in_item.item_value;
            r_rd_data <= mem[rd_addr];
        end
    end

    // Write a pushed value into the ring
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_value;
        end
    end

    // Execute the command on the latched item
    always_comb begin
        n_front            = r_front;
        n_count            = r_count;
        wr_en              = 1'b0;
        wr_addr            = tail_next;
        n_out.status       = deq_pkg::ST_OK;
        n_out.popped_value = '0;
        case (r_cmd)
            deq_pkg::CMD_PUSH_HEAD: begin
                if (is_full) begin
                    n_out.status = deq_pkg::ST_OVERFLOW;
                end else begin
                    n_front = front_dec;
                    wr_addr = front_dec;
                    wr_en   = i_dp_cmd.commit;
                    n_count = r_count + 1'b1;
                end
            end
            deq_pkg::CMD_PUSH_TAIL: begin
                if (is_full) begin
                    n_out.status = deq_pkg::ST_OVERFLOW;
                end else begin
                    wr_en   = i_dp_cmd.commit;
                    n_count = r_count + 1'b1;
                end
            end
            deq_pkg::CMD_POP_HEAD: begin
                if (is_empty) begin
                    n_out.status = deq_pkg::ST_UNDERFLOW;
                end else begin
                    n_out.popped_value = r_rd_data;
                    n_front            = front_inc;
                    n_count            = r_count - 1'b1;
                end
            end
            deq_pkg::CMD_POP_TAIL: begin
                if (is_empty) begin
                    n_out.status = deq_pkg::ST_UNDERFLOW;
                end else begin
                    n_out.popped_value = r_rd_data;
                    n_count            = r_count - 1'b1;
                end
            end
            default: begin
                n_front = r_front;
            end
        endcase
        count_ext        = 32'(n_count);
        n_out.item_count = count_ext[deq_pkg::COUNT_W-1:0];
        n_out.is_empty   = (n_count == '0);
    end

    // Advance the ring state on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_dp_cmd.commit) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // Load the result register on commit
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

endmodule

FILE: hw/rtl/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input deq_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input deq_pkg::t_out_item o_out_item
);

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // One item in work: the block stalls right after an accept
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while one is in work");

    // An empty flag goes with a zero count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_empty |-> o_out_item.item_count == '0)
        else $error("empty flag with nonzero count");

    // Underflow pops nothing and leaves the queue empty
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == deq_pkg::ST_UNDERFLOW
        |-> o_out_item.popped_value == '0 && o_out_item.is_empty)
        else $error("underflow result inconsistent");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
